FILE: design/vlmf_pkg.sv
// Package for the variable-length message FIFO.
// Holds sizes, result codes and the structs passed between front, queue and back.
// No dependencies.
`default_nettype none

package vlmf_pkg;

  // Ring geometry
  localparam int SLOTS     = 8;
  localparam int MSG_BYTES = 16;
  localparam int Q_DEPTH   = 4;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int LEN_W  = 5;
  localparam int CFG_W  = 5;
  localparam int ADDR_W = $clog2(SLOTS * MSG_BYTES);
  localparam int QPTR_W = $clog2(Q_DEPTH);

  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_RECV = 1'b1;

  typedef enum logic [2:0] {
    KIND_SENT  = 3'd0,
    KIND_FULL  = 3'd1,
    KIND_LONG  = 3'd2,
    KIND_RECV  = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    DISC_NONE = 2'd0,
    DISC_FULL = 2'd1,
    DISC_LONG = 2'd2
  } disc_t;

  // Command from front to back: either a finished result or a slot to stream
  typedef struct packed {
    logic              is_recv;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              full;
    logic              empty;
  } cmd_t;

  // Store write port driven by the front
  typedef struct packed {
    logic              mem_we;
    logic [SLOT_W-1:0] mem_slot;
    logic [IDX_W-1:0]  mem_idx;
    logic [7:0]        mem_data;
    logic              len_we;
    logic [SLOT_W-1:0] len_slot;
    logic [LEN_W-1:0]  len_val;
  } wr_t;

  // Read-side status reported by the back
  typedef struct packed {
    logic              active;
    logic              done;
    logic [SLOT_W-1:0] slot;
  } rd_stat_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) r = '0;
    else                         r = s + SLOT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/vlmf_queue.sv
// Short command queue between the front and the back of the message FIFO.
// Uses vlmf_pkg for the command struct and depth.
`default_nettype none

module vlmf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire vlmf_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output vlmf_pkg::cmd_t     head,
  output logic               valid
);
  import vlmf_pkg::*;

  cmd_t              q_r [Q_DEPTH];
  logic [QPTR_W:0]   wp_r, wp_nxt;
  logic [QPTR_W:0]   rp_r, rp_nxt;

  assign valid = (wp_r != rp_r);
  assign full  = (wp_r[QPTR_W-1:0] == rp_r[QPTR_W-1:0]) && (wp_r[QPTR_W] != rp_r[QPTR_W]);
  assign head  = q_r[rp_r[QPTR_W-1:0]];

  // Advance pointers
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = wp_r + (QPTR_W+1)'(1);
    if (pop)  rp_nxt = rp_r + (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r[QPTR_W-1:0]] <= push_cmd;
  end

endmodule

`default_nettype wire

FILE: design/vlmf_front.sv
// Front of the message FIFO: accepts send and receive transactions, tracks
// ring pointers and discard state, and issues store writes and commands.
// Uses vlmf_pkg.
`default_nettype none

module vlmf_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_action,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_end_of_message,
  input  wire logic                   cfg_valid,
  input  wire logic [vlmf_pkg::CFG_W-1:0] cfg_max_message_bytes,
  input  wire logic                   q_full,
  output logic                        q_push,
  output vlmf_pkg::cmd_t              q_cmd,
  output vlmf_pkg::wr_t               wr,
  input  wire vlmf_pkg::rd_stat_t     rd_stat
);
  import vlmf_pkg::*;

  logic [CFG_W-1:0]  cfg_r;
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [SLOT_W-1:0] rs_r, rs_nxt;
  logic              full_r, full_nxt;
  logic [LEN_W-1:0]  off_r, off_nxt;
  disc_t             disc_r, disc_nxt;
  logic              busy_r, busy_nxt;
  logic [SLOT_W-1:0] bslot_r, bslot_nxt;
  logic [LEN_W-1:0]  limit;
  logic              hazard;
  logic              in_acc;
  disc_t             dm;

  // Clamp the length limit to 1..MSG_BYTES
  always_comb begin
    if (cfg_r == '0)                         limit = LEN_W'(1);
    else if (int'(cfg_r) > MSG_BYTES)        limit = LEN_W'(MSG_BYTES);
    else                                     limit = LEN_W'(cfg_r);
  end

  // Hold receives while one streams; hold sends into the slot being read
  always_comb begin
    if (in_action == ACT_RECV) hazard = busy_r;
    else                       hazard = busy_r && (ws_r == bslot_r);
  end

  assign in_stall = q_full || hazard;
  assign in_acc   = in_valid && !in_stall;

  // Per-transaction update
  always_comb begin
    ws_nxt    = ws_r;
    rs_nxt    = rs_r;
    full_nxt  = full_r;
    off_nxt   = off_r;
    disc_nxt  = disc_r;
    busy_nxt  = busy_r;
    bslot_nxt = bslot_r;
    wr        = '0;
    q_push    = 1'b0;
    q_cmd     = '0;
    q_cmd.kind = KIND_SENT;
    dm        = disc_r;
    if (rd_stat.done) busy_nxt = 1'b0;
    if (in_acc) begin
      if (in_action == ACT_SEND) begin
        // Decide fullness on the first byte, then length
        if (dm == DISC_NONE && off_r == '0 && full_r) dm = DISC_FULL;
        if (dm == DISC_NONE) begin
          if (off_r >= limit) begin
            dm = DISC_LONG;
          end else begin
            wr.mem_we   = 1'b1;
            wr.mem_slot = ws_r;
            wr.mem_idx  = IDX_W'(off_r);
            wr.mem_data = in_data_byte;
            off_nxt     = off_r + LEN_W'(1);
          end
        end
        disc_nxt = dm;
        if (in_end_of_message) begin
          q_push = 1'b1;
          case (dm)
            DISC_FULL: q_cmd.kind = KIND_FULL;
            DISC_LONG: q_cmd.kind = KIND_LONG;
            default: begin
              q_cmd.kind  = KIND_SENT;
              q_cmd.len   = off_nxt;
              wr.len_we   = 1'b1;
              wr.len_slot = ws_r;
              wr.len_val  = off_nxt;
              ws_nxt      = next_slot(ws_r);
              if (next_slot(ws_r) == rs_r) full_nxt = 1'b1;
            end
          endcase
          off_nxt     = '0;
          disc_nxt    = DISC_NONE;
          q_cmd.full  = full_nxt;
          q_cmd.empty = (rs_nxt == ws_nxt) && !full_nxt;
        end
      end else begin
        q_push = 1'b1;
        if (rs_r == ws_r && !full_r) begin
          q_cmd.kind  = KIND_EMPTY;
          q_cmd.full  = 1'b0;
          q_cmd.empty = 1'b1;
        end else begin
          q_cmd.is_recv = 1'b1;
          q_cmd.kind    = KIND_RECV;
          q_cmd.slot    = rs_r;
          rs_nxt        = next_slot(rs_r);
          full_nxt      = 1'b0;
          busy_nxt      = 1'b1;
          bslot_nxt     = rs_r;
          q_cmd.full    = 1'b0;
          q_cmd.empty   = (next_slot(rs_r) == ws_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= CFG_W'(16);
      ws_r    <= '0;
      rs_r    <= '0;
      full_r  <= 1'b0;
      off_r   <= '0;
      disc_r  <= DISC_NONE;
      busy_r  <= 1'b0;
      bslot_r <= '0;
    end else begin
      if (cfg_valid) cfg_r <= cfg_max_message_bytes;
      ws_r    <= ws_nxt;
      rs_r    <= rs_nxt;
      full_r  <= full_nxt;
      off_r   <= off_nxt;
      disc_r  <= disc_nxt;
      busy_r  <= busy_nxt;
      bslot_r <= bslot_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/vlmf_back.sv
// Back of the message FIFO: owns the message and length stores, pops
// commands and drives the registered result channel.
// Uses vlmf_pkg.
`default_nettype none

module vlmf_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire vlmf_pkg::cmd_t         q_head,
  output logic                        q_pop,
  input  wire vlmf_pkg::wr_t          wr,
  output vlmf_pkg::rd_stat_t          rd_stat,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  out_kind,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_message,
  output logic [vlmf_pkg::LEN_W-1:0]  out_message_length,
  output logic                        out_full_flag,
  output logic                        out_empty_flag
);
  import vlmf_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE   = 2'b01,
    B_STREAM = 2'b10
  } bstate_t;

  logic [7:0]        msg_mem [SLOTS * MSG_BYTES];
  logic [LEN_W-1:0]  len_mem [SLOTS];

  bstate_t           st_r, st_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              fl_full_r, fl_full_nxt;
  logic              fl_empty_r, fl_empty_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [7:0]        rd_data_r;
  logic              ov_r, ov_nxt;
  logic              out_free;
  logic              load;
  logic              last;
  logic              done;
  logic              len_rd;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  kind_t             o_kind_nxt;
  logic [7:0]        o_byte_nxt;
  logic              o_last_nxt;
  logic [LEN_W-1:0]  o_len_nxt;
  logic              o_full_nxt;
  logic              o_empty_nxt;

  assign out_free = !ov_r || !out_stall;
  assign last     = (LEN_W'(idx_r) + LEN_W'(1)) == len_r;

  // Sequence commands and streamed bytes
  always_comb begin
    st_nxt       = st_r;
    slot_nxt     = slot_r;
    idx_nxt      = idx_r;
    fl_full_nxt  = fl_full_r;
    fl_empty_nxt = fl_empty_r;
    q_pop        = 1'b0;
    load         = 1'b0;
    done         = 1'b0;
    len_rd       = 1'b0;
    o_kind_nxt   = q_head.kind;
    o_byte_nxt   = '0;
    o_last_nxt   = 1'b0;
    o_len_nxt    = q_head.len;
    o_full_nxt   = q_head.full;
    o_empty_nxt  = q_head.empty;
    case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          if (q_head.is_recv) begin
            q_pop        = 1'b1;
            len_rd       = 1'b1;
            slot_nxt     = q_head.slot;
            idx_nxt      = '0;
            fl_full_nxt  = q_head.full;
            fl_empty_nxt = q_head.empty;
            st_nxt       = B_STREAM;
          end else if (out_free) begin
            q_pop = 1'b1;
            load  = 1'b1;
          end
        end
      end
      B_STREAM: begin
        if (out_free) begin
          load        = 1'b1;
          o_kind_nxt  = KIND_RECV;
          o_byte_nxt  = rd_data_r;
          o_last_nxt  = last;
          o_len_nxt   = len_r;
          o_full_nxt  = fl_full_r;
          o_empty_nxt = fl_empty_r;
          if (last) begin
            done   = 1'b1;
            st_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    if (load)           ov_nxt = 1'b1;
    else if (!out_stall) ov_nxt = 1'b0;
    else                ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Hold read position and flags of the message being streamed
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    fl_full_r  <= fl_full_nxt;
    fl_empty_r <= fl_empty_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind            <= o_kind_nxt;
      out_byte            <= o_byte_nxt;
      out_last_of_message <= o_last_nxt;
      out_message_length  <= o_len_nxt;
      out_full_flag       <= o_full_nxt;
      out_empty_flag      <= o_empty_nxt;
    end
  end

  assign out_valid = ov_r;

  // Message store: one write port, one registered read port
  assign wr_addr = ADDR_W'(wr.mem_slot) * ADDR_W'(MSG_BYTES) + ADDR_W'(wr.mem_idx);
  assign rd_addr = ADDR_W'(slot_nxt) * ADDR_W'(MSG_BYTES) + ADDR_W'(idx_nxt);

  always_ff @(posedge clk) begin
    if (wr.mem_we) msg_mem[wr_addr] <= wr.mem_data;
    rd_data_r <= msg_mem[rd_addr];
  end

  // Length store
  always_ff @(posedge clk) begin
    if (wr.len_we) len_mem[wr.len_slot] <= wr.len_val;
    if (len_rd)    len_r <= len_mem[q_head.slot];
  end

  assign rd_stat.active = (st_r == B_STREAM);
  assign rd_stat.done   = done;
  assign rd_stat.slot   = slot_r;

endmodule

`default_nettype wire

FILE: design/variable_length_message_fifo_top.sv
// Top level of the variable-length message FIFO.
// Instantiates vlmf_front, vlmf_queue and vlmf_back; uses vlmf_pkg.
`default_nettype none

// A ring of 8 slots of 16 bytes each holds whole messages. A send transaction
// carries one byte; only its last byte produces a result (sent, rejected
// full or rejected too long). A receive transaction fetches the oldest slot's
// length and first byte and then streams one result per byte, one per cycle
// while out_stall is low, through the output register. The store has a
// single read port, so while a message streams out, further receives and
// sends into the slot being read are held with in_stall; sends into other
// slots keep going. A four-entry command queue sits between the front and
// the back. The stores need no clearing after reset. The length limit is
// written through cfg_max_message_bytes, which is always ready.
module variable_length_message_fifo_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_action,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_end_of_message,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_message,
  output logic [vlmf_pkg::LEN_W-1:0]     out_message_length,
  output logic                           out_full_flag,
  output logic                           out_empty_flag,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [vlmf_pkg::CFG_W-1:0] cfg_max_message_bytes
);
  import vlmf_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  cmd_t     q_cmd;
  cmd_t     q_head;
  wr_t      wr;
  rd_stat_t rd_stat;

  assign cfg_ready = 1'b1;

  vlmf_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_data_byte          (in_data_byte),
    .in_end_of_message     (in_end_of_message),
    .cfg_valid             (cfg_valid),
    .cfg_max_message_bytes (cfg_max_message_bytes),
    .q_full                (q_full),
    .q_push                (q_push),
    .q_cmd                 (q_cmd),
    .wr                    (wr),
    .rd_stat               (rd_stat)
  );

  vlmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .valid    (q_valid)
  );

  vlmf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .wr                  (wr),
    .rd_stat             (rd_stat),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_byte            (out_byte),
    .out_last_of_message (out_last_of_message),
    .out_message_length  (out_message_length),
    .out_full_flag       (out_full_flag),
    .out_empty_flag      (out_empty_flag)
  );

  // Never write into the slot that is streaming out
  a_no_wr_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.mem_we && rd_stat.active) |-> (wr.mem_slot != rd_stat.slot))
    else $error("store write hits the slot being read");

  // Never push into a full command queue
  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("command queue overflow");

  // The last streamed byte is presented on the next cycle
  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    rd_stat.done |=> (out_valid && out_last_of_message && out_kind == KIND_RECV))
    else $error("last byte of message not presented");

  // A queue cannot be full and empty at once
  a_flags_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_full_flag && out_empty_flag))
    else $error("full and empty flags both set");

endmodule

`default_nettype wire
